FILE: design/tip_ordered_pending_pool_top_assert.svh
// Assertion macros used by the tip-ordered pending pool top module.
`ifndef TIP_ORDERED_PENDING_POOL_TOP_ASSERT_SVH
`define TIP_ORDERED_PENDING_POOL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TOPP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("topp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TOPP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("topp assertion failed");

`endif

FILE: design/topp_pkg.sv
// Shared types, codes and constants of the tip-ordered pending pool.
package topp_pkg;

    localparam int DEF_POOL_DEPTH = 64;
    localparam int S_TDATA_W      = 496;
    localparam int M_TDATA_W      = 368;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_PRUNE  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [2:0] ST_ACCEPTED     = 3'd0;
    localparam logic [2:0] ST_DUPLICATE    = 3'd1;
    localparam logic [2:0] ST_WRONG_CHAIN  = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
    localparam logic [2:0] ST_EXPIRED      = 3'd4;
    localparam logic [2:0] ST_FULL_LOW_TIP = 3'd5;
    localparam logic [2:0] ST_DONE         = 3'd6;

    localparam logic CFG_CHAIN_ID    = 1'b0;
    localparam logic CFG_REQ_VERSION = 1'b1;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] sender;
        logic [63:0] seq;
        logic [63:0] tip;
        logic [63:0] expiry;
        logic [31:0] payload;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic key_eq;
        logic snd_eq;
        logic tip_lt;
        logic exp_le;
    } t_cmp_flags;

endpackage

FILE: design/topp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module topp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/topp_cmp.sv
// Shared compare unit: matches one stored entry against the current request.
module topp_cmp (
    input  topp_pkg::t_entry     i_entry,
    input  logic [63:0]          i_key,
    input  logic [63:0]          i_sender,
    input  logic [63:0]          i_seq,
    input  logic [63:0]          i_tip,
    input  logic [63:0]          i_now,
    output topp_pkg::t_cmp_flags o_flags
);
    import topp_pkg::*;

    always_comb begin
        o_flags.key_eq = (i_entry.key == i_key);
        o_flags.snd_eq = (i_entry.sender == i_sender) && (i_entry.seq == i_seq);
        o_flags.tip_lt = (i_entry.tip < i_tip);
        o_flags.exp_le = (i_entry.expiry <= i_now);
    end
endmodule

FILE: design/tip_ordered_pending_pool_top.sv
// Top level of the tip-ordered pending pool: sequencer, entry memory and compare unit.
`include "tip_ordered_pending_pool_top_assert.svh"

// The pool keeps up to POOL_DEPTH entries in one RAM, sorted by tip with the
// highest first, and walks them one entry per cycle through a single shared
// compare unit. One item is handled at a time; the input is ready only when
// the block is idle and the last result has been taken. Lookup and prune run
// one scan of the stored entries, remove a key scan and a shift toward the
// head, an add a key scan, removal of a replaced entry, a position scan, a
// shift toward the tail and a write, and read out emits one entry at a time.
// The single RAM read port sets the pace of all of these. The entry memory
// needs no clearing after reset: only entries below the count are ever read.
module tip_ordered_pending_pool_top #(
    parameter int POOL_DEPTH = topp_pkg::DEF_POOL_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // item_key, sender_tag, seq_number, tip_value, expiry_slot, item_chain,
    // item_version, now_slot, read_limit, payload_ref, one pad bit
    input  logic [topp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic [2:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pool_count, dropped_count, out_key, out_sender, out_seq, out_tip,
    // out_expiry, out_payload, two pad bits
    output logic [topp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status, found
    output logic [3:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import topp_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_DOWN  = 11'b00000001000,
        S_FIND  = 11'b00000010000,
        S_UP    = 11'b00000100000,
        S_WRITE = 11'b00001000000,
        S_PRUNE = 11'b00010000000,
        S_RDREQ = 11'b00100000000,
        S_RDDAT = 11'b01000000000,
        S_RESP  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_op;
    logic [63:0] r_cfg_chain, n_cfg_chain;
    logic [7:0] r_cfg_ver, n_cfg_ver;

    logic [63:0] r_req_key, r_req_sender, r_req_seq, r_req_tip, r_req_expiry;
    logic [63:0] r_req_chain, r_req_now;
    logic [7:0] r_req_ver;
    logic [6:0] r_req_lim;
    logic [31:0] r_req_payload;

    logic [CW-1:0] r_occ, n_occ;
    logic [CW-1:0] r_ridx, n_ridx;
    logic [CW-1:0] r_pidx, n_pidx;
    logic r_pv, n_pv;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_drop, n_drop;
    logic r_key_hit, n_key_hit;
    logic [CW-1:0] r_key_idx, n_key_idx;
    logic r_snd_hit, n_snd_hit;
    logic [CW-1:0] r_snd_idx, n_snd_idx;
    logic [63:0] r_snd_tip, n_snd_tip;
    logic r_pos_hit, n_pos_hit;
    logic [CW-1:0] r_pos, n_pos;
    logic [63:0] r_last_tip, n_last_tip;
    logic [6:0] r_nread, n_nread;

    logic r_out_valid, n_out_valid;
    logic [2:0] r_o_status, n_o_status;
    logic r_o_found, n_o_found;
    logic [6:0] r_o_count, n_o_count;
    logic [6:0] r_o_drop, n_o_drop;
    t_entry r_o_entry, n_o_entry;
    logic r_o_last, n_o_last;

    logic res_go;
    logic [2:0] res_status;
    logic res_found;
    logic [CW-1:0] res_count;
    logic [CW-1:0] res_drop;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    t_entry rd_entry, new_entry;
    t_cmp_flags flags;

    logic in_accept;
    logic [6:0] occ7;
    logic [CW-1:0] occ_new;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign rd_entry = t_entry'(ram_rdata);
    assign occ7 = 7'(r_occ);

    always_comb begin
        new_entry.key     = r_req_key;
        new_entry.sender  = r_req_sender;
        new_entry.seq     = r_req_seq;
        new_entry.tip     = r_req_tip;
        new_entry.expiry  = r_req_expiry;
        new_entry.payload = r_req_payload;
    end

    topp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    topp_cmp u_cmp (
        .i_entry  (rd_entry),
        .i_key    (r_req_key),
        .i_sender (r_req_sender),
        .i_seq    (r_req_seq),
        .i_tip    (r_req_tip),
        .i_now    (r_req_now),
        .o_flags  (flags)
    );

    always_comb begin
        n_state     = r_state;
        n_cfg_chain = r_cfg_chain;
        n_cfg_ver   = r_cfg_ver;
        n_occ       = r_occ;
        n_ridx      = r_ridx;
        n_pidx      = r_pidx;
        n_pv        = 1'b0;
        n_w         = r_w;
        n_drop      = r_drop;
        n_key_hit   = r_key_hit;
        n_key_idx   = r_key_idx;
        n_snd_hit   = r_snd_hit;
        n_snd_idx   = r_snd_idx;
        n_snd_tip   = r_snd_tip;
        n_pos_hit   = r_pos_hit;
        n_pos       = r_pos;
        n_last_tip  = r_last_tip;
        n_nread     = r_nread;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_found   = r_o_found;
        n_o_count   = r_o_count;
        n_o_drop    = r_o_drop;
        n_o_entry   = r_o_entry;
        n_o_last    = r_o_last;
        res_go      = 1'b0;
        res_status  = ST_DONE;
        res_found   = 1'b0;
        res_count   = r_occ;
        res_drop    = '0;
        ram_we      = 1'b0;
        ram_waddr   = r_pidx[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_ridx[AW-1:0];
        occ_new     = r_occ;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHAIN_ID:    n_cfg_chain = i_cfg_data;
                CFG_REQ_VERSION: n_cfg_ver = i_cfg_data[7:0];
                default:         n_cfg_chain = r_cfg_chain;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_ridx    = '0;
                n_key_hit = 1'b0;
                n_snd_hit = 1'b0;
                n_w       = '0;
                n_drop    = '0;
                unique case (r_op) inside
                    OP_ADD: begin
                        if (r_req_chain != r_cfg_chain) begin
                            res_go = 1'b1;
                            res_status = ST_WRONG_CHAIN;
                        end else if (r_req_ver != r_cfg_ver) begin
                            res_go = 1'b1;
                            res_status = ST_BAD_VERSION;
                        end else if (r_req_now >= r_req_expiry) begin
                            res_go = 1'b1;
                            res_status = ST_EXPIRED;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_LOOKUP, OP_REMOVE: n_state = S_SCAN;
                    OP_PRUNE:             n_state = S_PRUNE;
                    OP_READ: begin
                        n_nread = (occ7 < r_req_lim) ? occ7 : r_req_lim;
                        if (n_nread == '0) begin
                            res_go = 1'b1;
                        end else begin
                            n_state = S_RDREQ;
                        end
                    end
                    default: res_go = 1'b1;
                endcase
            end
            S_SCAN: begin
                if (r_ridx < r_occ) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pidx = r_ridx;
                    n_pv   = 1'b1;
                end
                if (r_pv) begin
                    if (flags.key_eq && !r_key_hit) begin
                        n_key_hit = 1'b1;
                        n_key_idx = r_pidx;
                    end
                    if (flags.snd_eq && !r_snd_hit) begin
                        n_snd_hit = 1'b1;
                        n_snd_idx = r_pidx;
                        n_snd_tip = rd_entry.tip;
                    end
                end else if (r_ridx >= r_occ) begin
                    n_pos_hit = 1'b0;
                    if (r_op == OP_LOOKUP) begin
                        res_go = 1'b1;
                        res_found = r_key_hit;
                    end else if (r_op == OP_REMOVE) begin
                        if (r_key_hit) begin
                            n_ridx = r_key_idx;
                            n_state = S_DOWN;
                        end else begin
                            res_go = 1'b1;
                        end
                    end else if (r_key_hit) begin
                        res_go = 1'b1;
                        res_status = ST_DUPLICATE;
                    end else if (r_snd_hit) begin
                        if (r_req_tip <= r_snd_tip) begin
                            res_go = 1'b1;
                            res_status = ST_DUPLICATE;
                        end else begin
                            // The newer nonce holder with a higher tip replaces the old one.
                            n_ridx = r_snd_idx;
                            n_state = S_DOWN;
                        end
                    end else begin
                        n_ridx = '0;
                        n_state = S_FIND;
                    end
                end
            end
            S_DOWN: begin
                ram_raddr = AW'(r_ridx + 1'b1);
                if ((CW + 1)'(r_ridx) + 1'b1 < (CW + 1)'(r_occ)) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pidx = r_ridx;
                    n_pv   = 1'b1;
                end
                if (r_pv) begin
                    ram_we = 1'b1;
                end else if (!((CW + 1)'(r_ridx) + 1'b1 < (CW + 1)'(r_occ))) begin
                    n_occ = r_occ - 1'b1;
                    if (r_op == OP_REMOVE) begin
                        res_go = 1'b1;
                        res_found = 1'b1;
                        res_count = r_occ - 1'b1;
                    end else begin
                        n_ridx = '0;
                        n_pos_hit = 1'b0;
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (r_ridx < r_occ) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pidx = r_ridx;
                    n_pv   = 1'b1;
                end
                if (r_pv) begin
                    if (flags.tip_lt && !r_pos_hit) begin
                        n_pos_hit = 1'b1;
                        n_pos = r_pidx;
                    end
                    if (r_pidx == r_occ - 1'b1) begin
                        n_last_tip = rd_entry.tip;
                    end
                end else if (r_ridx >= r_occ) begin
                    if (r_occ == CW'(POOL_DEPTH) && r_last_tip >= r_req_tip) begin
                        res_go = 1'b1;
                        res_status = ST_FULL_LOW_TIP;
                    end else begin
                        // A full table drops its tail entry to make room.
                        occ_new = (r_occ == CW'(POOL_DEPTH)) ? r_occ - 1'b1 : r_occ;
                        n_occ  = occ_new;
                        n_pos  = r_pos_hit ? r_pos : occ_new;
                        n_ridx = occ_new;
                        n_state = S_UP;
                    end
                end
            end
            S_UP: begin
                ram_raddr = AW'(r_ridx - 1'b1);
                if (r_ridx > r_pos) begin
                    n_ridx = r_ridx - 1'b1;
                    n_pidx = r_ridx;
                    n_pv   = 1'b1;
                end
                if (r_pv) begin
                    ram_we = 1'b1;
                end else if (r_ridx <= r_pos) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = new_entry;
                n_occ     = r_occ + 1'b1;
                res_go    = 1'b1;
                res_status = ST_ACCEPTED;
                res_count = r_occ + 1'b1;
            end
            S_PRUNE: begin
                if (r_ridx < r_occ) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pidx = r_ridx;
                    n_pv   = 1'b1;
                end
                ram_waddr = r_w[AW-1:0];
                if (r_pv) begin
                    if (flags.exp_le) begin
                        n_drop = r_drop + 1'b1;
                    end else begin
                        ram_we = 1'b1;
                        n_w = r_w + 1'b1;
                    end
                end else if (r_ridx >= r_occ) begin
                    n_occ = r_w;
                    res_go = 1'b1;
                    res_count = r_w;
                    res_drop = r_drop;
                end
            end
            S_RDREQ: begin
                n_state = S_RDDAT;
            end
            S_RDDAT: begin
                n_out_valid = 1'b1;
                n_o_status  = ST_DONE;
                n_o_found   = 1'b1;
                n_o_count   = occ7;
                n_o_drop    = '0;
                n_o_entry   = rd_entry;
                n_o_last    = (7'(r_ridx) + 1'b1 == r_nread);
                n_ridx      = r_ridx + 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                    n_state = (r_op == OP_READ && !r_o_last) ? S_RDREQ : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (res_go) begin
            n_out_valid = 1'b1;
            n_o_status  = res_status;
            n_o_found   = res_found;
            n_o_count   = 7'(res_count);
            n_o_drop    = 7'(res_drop);
            n_o_entry   = '0;
            n_o_last    = 1'b1;
            n_state     = S_RESP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_chain <= '0;
            r_cfg_ver   <= 8'd1;
            r_occ       <= '0;
            r_ridx      <= '0;
            r_pidx      <= '0;
            r_pv        <= 1'b0;
            r_w         <= '0;
            r_drop      <= '0;
            r_key_hit   <= 1'b0;
            r_key_idx   <= '0;
            r_snd_hit   <= 1'b0;
            r_snd_idx   <= '0;
            r_pos_hit   <= 1'b0;
            r_pos       <= '0;
            r_nread     <= '0;
            r_out_valid <= 1'b0;
            r_o_last    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_chain <= n_cfg_chain;
            r_cfg_ver   <= n_cfg_ver;
            r_occ       <= n_occ;
            r_ridx      <= n_ridx;
            r_pidx      <= n_pidx;
            r_pv        <= n_pv;
            r_w         <= n_w;
            r_drop      <= n_drop;
            r_key_hit   <= n_key_hit;
            r_key_idx   <= n_key_idx;
            r_snd_hit   <= n_snd_hit;
            r_snd_idx   <= n_snd_idx;
            r_pos_hit   <= n_pos_hit;
            r_pos       <= n_pos;
            r_nread     <= n_nread;
            r_out_valid <= n_out_valid;
            r_o_last    <= n_o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snd_tip  <= n_snd_tip;
        r_last_tip <= n_last_tip;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_count  <= n_o_count;
        r_o_drop   <= n_o_drop;
        r_o_entry  <= n_o_entry;
        if (in_accept) begin
            r_op          <= s_axis_tuser;
            r_req_key     <= s_axis_tdata[63:0];
            r_req_sender  <= s_axis_tdata[127:64];
            r_req_seq     <= s_axis_tdata[191:128];
            r_req_tip     <= s_axis_tdata[255:192];
            r_req_expiry  <= s_axis_tdata[319:256];
            r_req_chain   <= s_axis_tdata[383:320];
            r_req_ver     <= s_axis_tdata[391:384];
            r_req_now     <= s_axis_tdata[455:392];
            r_req_lim     <= s_axis_tdata[462:456];
            r_req_payload <= s_axis_tdata[494:463];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = {r_o_found, r_o_status};
    assign m_axis_tdata  = {2'b00, r_o_entry.payload, r_o_entry.expiry, r_o_entry.tip,
                            r_o_entry.seq, r_o_entry.sender, r_o_entry.key,
                            r_o_drop, r_o_count};

    `TOPP_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CW'(POOL_DEPTH))
    `TOPP_ASSERT_NXT(a_idle_occ, i_clk, i_rst_n, r_state == S_IDLE, $stable(r_occ))
    `TOPP_ASSERT_IMP(a_ready_quiet, i_clk, i_rst_n, s_axis_tready, !r_out_valid && !ram_we)
    `TOPP_ASSERT_IMP(a_we_states, i_clk, i_rst_n, ram_we,
        r_state == S_DOWN || r_state == S_UP || r_state == S_WRITE || r_state == S_PRUNE)
endmodule

FILE: tb/tip_ordered_pending_pool_top_test.sv
// Self-checking testbench of the tip-ordered pending pool with its own table predictor.
`timescale 1ns / 1ps

module tip_ordered_pending_pool_top_test;
    import topp_pkg::*;

    localparam int DEPTH      = DEF_POOL_DEPTH;
    localparam int IDLE_LIMIT = 20000;

    // Op codes that the pool does not define.
    localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] key;
        logic [63:0] sender;
        logic [63:0] seq;
        logic [63:0] tip;
        logic [63:0] expiry;
        logic [63:0] chain;
        logic [7:0]  ver;
        logic [63:0] now_slot;
        logic [6:0]  lim;
        logic [31:0] payload;
    } t_pool_req;

    typedef struct {
        logic [2:0] status;
        logic       found;
        logic [6:0] count;
        logic [6:0] dropped;
        t_entry     ent;
        logic       last;
    } t_pool_resp;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [63:0]          i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [2:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [3:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    tip_ordered_pending_pool_top DUT (.*);

    // Predicted pool contents and registers.
    t_entry      table_ent [DEPTH];
    int          table_occ;
    logic [63:0] chain_reg;
    logic [7:0]  version_reg;

    t_pool_req   pending_reqs[$];
    t_pool_resp  expected_resps[$];
    t_pool_req   cur_req;
    logic [63:0] key_history[$];
    logic [63:0] sender_history[$];
    logic [63:0] seq_history[$];
    logic [63:0] gen_now;

    int n_accepted, n_results, n_errors, n_reads, n_evict_tries, peak_occ;
    int burst_left, gap_left, hold_left, rx_cycle, idle_cycles;
    bit did_hold;

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_resp(logic [2:0] st, logic fnd, logic [6:0] drp,
                                      t_entry e, logic lst);
        t_pool_resp r;
        r.status  = st;
        r.found   = fnd;
        r.count   = table_occ[6:0];
        r.dropped = drp;
        r.ent     = e;
        r.last    = lst;
        expected_resps.push_back(r);
    endfunction

    function automatic int find_key(logic [63:0] k);
        for (int i = 0; i < table_occ; i++)
            if (table_ent[i].key == k) return i;
        return -1;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < table_occ; i++) table_ent[i] = table_ent[i + 1];
        table_occ--;
    endfunction

    function automatic logic [2:0] predict_add(t_pool_req q);
        int pos;
        if (q.chain != chain_reg) return ST_WRONG_CHAIN;
        if (q.ver != version_reg) return ST_BAD_VERSION;
        if (q.now_slot >= q.expiry) return ST_EXPIRED;
        if (find_key(q.key) >= 0) return ST_DUPLICATE;
        for (int i = 0; i < table_occ; i++) begin
            if (table_ent[i].seq == q.seq && table_ent[i].sender == q.sender) begin
                if (q.tip <= table_ent[i].tip) return ST_DUPLICATE;
                drop_entry(i);
                break;
            end
        end
        if (table_occ >= DEPTH) begin
            n_evict_tries++;
            if (table_ent[table_occ - 1].tip >= q.tip) return ST_FULL_LOW_TIP;
            table_occ--;
        end
        pos = table_occ;
        for (int i = 0; i < table_occ; i++) begin
            if (table_ent[i].tip < q.tip) begin
                pos = i;
                break;
            end
        end
        for (int i = table_occ; i > pos; i--) table_ent[i] = table_ent[i - 1];
        table_ent[pos] = '{q.key, q.sender, q.seq, q.tip, q.expiry, q.payload};
        table_occ++;
        return ST_ACCEPTED;
    endfunction

    // Works out every result that one accepted item causes.
    function automatic void predict_pool(t_pool_req q);
        int     hit, w, n, drp;
        t_entry blank;
        blank = '0;
        case (q.op)
            OP_ADD: push_resp(predict_add(q), 1'b0, 7'd0, blank, 1'b1);
            OP_LOOKUP: push_resp(ST_DONE, find_key(q.key) >= 0, 7'd0, blank, 1'b1);
            OP_REMOVE: begin
                hit = find_key(q.key);
                if (hit >= 0) drop_entry(hit);
                push_resp(ST_DONE, hit >= 0, 7'd0, blank, 1'b1);
            end
            OP_PRUNE: begin
                w   = 0;
                drp = 0;
                for (int i = 0; i < table_occ; i++) begin
                    if (table_ent[i].expiry <= q.now_slot) begin
                        drp++;
                    end else begin
                        table_ent[w] = table_ent[i];
                        w++;
                    end
                end
                table_occ = w;
                push_resp(ST_DONE, 1'b0, drp[6:0], blank, 1'b1);
            end
            OP_READ: begin
                n_reads++;
                n = (table_occ < q.lim) ? table_occ : q.lim;
                if (n == 0) push_resp(ST_DONE, 1'b0, 7'd0, blank, 1'b1);
                for (int i = 0; i < n; i++)
                    push_resp(ST_DONE, 1'b1, 7'd0, table_ent[i], i + 1 == n);
            end
            default: push_resp(ST_DONE, 1'b0, 7'd0, blank, 1'b1);
        endcase
        if (table_occ > peak_occ) peak_occ = table_occ;
    endfunction

    function automatic t_pool_req make_add(logic [63:0] k, logic [63:0] snd,
                                           logic [63:0] sq, logic [63:0] tp,
                                           logic [63:0] exp_slot, logic [63:0] nw);
        t_pool_req q;
        q = '{OP_ADD, k, snd, sq, tp, exp_slot, chain_reg, version_reg, nw, 7'd0,
              $urandom};
        key_history.push_back(k);
        sender_history.push_back(snd);
        seq_history.push_back(sq);
        return q;
    endfunction

    function automatic t_pool_req make_op(logic [2:0] op, logic [63:0] k,
                                          logic [63:0] nw, logic [6:0] lim);
        t_pool_req q;
        q = '{op, k, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), 8'($urandom), nw, lim,
              $urandom};
        return q;
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_history.size() == 0 || $urandom_range(0, 2) == 0) return rnd64();
        return key_history[$urandom_range(0, key_history.size() - 1)];
    endfunction

    // One random item; long_life adds only well-formed adds that outlive every prune.
    function automatic t_pool_req gen_item(bit long_life);
        t_pool_req q;
        int        r, h, kind;
        logic [63:0] snd, sq, tp;
        r = long_life ? 0 : $urandom_range(0, 99);
        gen_now += 64'($urandom_range(0, 3));
        if (r < 55) begin
            snd = rnd64();
            sq  = rnd64();
            if (sender_history.size() > 0 && $urandom_range(0, 4) == 0) begin
                h   = $urandom_range(0, sender_history.size() - 1);
                snd = sender_history[h];
                sq  = seq_history[h];
            end
            tp = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 15)) : rnd64();
            q  = make_add(($urandom_range(0, 4) == 0 && !long_life) ? pick_key() : rnd64(),
                          snd, sq, tp,
                          gen_now + (long_life ? 64'd1000000 : 64'($urandom_range(1, 300))),
                          gen_now);
            kind = long_life ? 0 : $urandom_range(0, 19);
            if (kind == 1) q.chain = rnd64();
            else if (kind == 2) q.ver = 8'($urandom);
            else if (kind == 3) q.expiry = gen_now - 64'($urandom_range(0, 5));
        end else if (r < 65) begin
            q = make_op(OP_LOOKUP, pick_key(), rnd64(), 7'($urandom));
        end else if (r < 75) begin
            q = make_op(OP_REMOVE, pick_key(), rnd64(), 7'($urandom));
        end else if (r < 80) begin
            q = make_op(OP_PRUNE, rnd64(), gen_now, 7'($urandom));
        end else if (r < 97) begin
            q = make_op(OP_READ, rnd64(), rnd64(),
                        7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64)
                                                       : $urandom_range(0, 8)));
        end else begin
            q = make_op(3'($urandom_range(32'(OP_UNKNOWN_LO), 32'(OP_UNKNOWN_HI))),
                        rnd64(), rnd64(), 7'($urandom));
        end
        return q;
    endfunction

    task automatic write_reg(logic idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CHAIN_ID) chain_reg = val;
        else version_reg = val[7:0];
    endtask

    task automatic drain_pool();
        wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_resps.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pool(cur_req);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {1'b0, cur_req.payload, cur_req.lim, cur_req.now_slot,
                                     cur_req.ver, cur_req.chain, cur_req.expiry,
                                     cur_req.tip, cur_req.seq, cur_req.sender,
                                     cur_req.key};
                    s_axis_tuser  <= cur_req.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: alternates between free-running and stalling stretches, with
    // one long hold-off that backs the pool up into its input.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!did_hold && n_accepted >= 200) begin
            did_hold  = 1'b1;
            hold_left = 600;
            m_axis_tready <= 1'b0;
        end else if (rx_cycle[8]) begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_pool_resp x;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_resps.size() == 0) begin
                $error("result with nothing expected: tdata %h", m_axis_tdata);
                n_errors++;
            end else begin
                x = expected_resps.pop_front();
                if (m_axis_tuser[2:0] !== x.status) begin
                    $error("status: expected %0d actual %0d", x.status, m_axis_tuser[2:0]);
                    n_errors++;
                end
                if (m_axis_tuser[3] !== x.found) begin
                    $error("found: expected %0d actual %0d", x.found, m_axis_tuser[3]);
                    n_errors++;
                end
                if (m_axis_tdata[6:0] !== x.count) begin
                    $error("pool_count: expected %0d actual %0d", x.count, m_axis_tdata[6:0]);
                    n_errors++;
                end
                if (m_axis_tdata[13:7] !== x.dropped) begin
                    $error("dropped_count: expected %0d actual %0d", x.dropped,
                           m_axis_tdata[13:7]);
                    n_errors++;
                end
                if (m_axis_tdata[77:14] !== x.ent.key) begin
                    $error("out_key: expected %h actual %h", x.ent.key, m_axis_tdata[77:14]);
                    n_errors++;
                end
                if (m_axis_tdata[141:78] !== x.ent.sender) begin
                    $error("out_sender: expected %h actual %h", x.ent.sender,
                           m_axis_tdata[141:78]);
                    n_errors++;
                end
                if (m_axis_tdata[205:142] !== x.ent.seq) begin
                    $error("out_seq: expected %h actual %h", x.ent.seq, m_axis_tdata[205:142]);
                    n_errors++;
                end
                if (m_axis_tdata[269:206] !== x.ent.tip) begin
                    $error("out_tip: expected %h actual %h", x.ent.tip, m_axis_tdata[269:206]);
                    n_errors++;
                end
                if (m_axis_tdata[333:270] !== x.ent.expiry) begin
                    $error("out_expiry: expected %h actual %h", x.ent.expiry,
                           m_axis_tdata[333:270]);
                    n_errors++;
                end
                if (m_axis_tdata[365:334] !== x.ent.payload) begin
                    $error("out_payload: expected %h actual %h", x.ent.payload,
                           m_axis_tdata[365:334]);
                    n_errors++;
                end
                if (m_axis_tlast !== x.last) begin
                    $error("last: expected %0d actual %0d", x.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [63:0] ones;
        ones          = '1;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_CHAIN_ID;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        m_axis_tready = 1'b0;
        chain_reg     = '0;
        version_reg   = 8'd1;
        table_occ     = 0;
        gen_now       = 64'd100;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset register values.
        pending_reqs.push_back(make_op(OP_READ, '0, '0, 7'd0));
        pending_reqs.push_back(make_add('0, '0, '0, '0, 64'd1, '0));
        pending_reqs.push_back(make_add(ones, ones, ones, ones, ones, ones - 64'd1));
        pending_reqs.push_back(make_add(64'd5, 64'd7, 64'd9, 64'd50, 64'd500, 64'd10));
        pending_reqs.push_back(make_add(64'd6, 64'd8, 64'd9, 64'd50, 64'd600, 64'd10));
        pending_reqs.push_back(make_add(64'd5, 64'd1, 64'd2, 64'd3, 64'd900, 64'd10));
        pending_reqs.push_back(make_add(64'd11, 64'd7, 64'd9, 64'd40, 64'd900, 64'd10));
        pending_reqs.push_back(make_add(64'd12, 64'd7, 64'd9, 64'd60, 64'd900, 64'd10));
        pending_reqs.push_back(make_add(64'd13, 64'd3, 64'd3, 64'd9, ones, ones));
        pending_reqs.push_back(make_add(64'd14, 64'd3, 64'd4, 64'd9, 64'd20, 64'd20));
        cur_req = make_add(64'd15, 64'd3, 64'd5, 64'd9, 64'd50, 64'd10);
        cur_req.chain = 64'd1;
        pending_reqs.push_back(cur_req);
        cur_req.chain = '0;
        cur_req.ver   = 8'hFE;
        pending_reqs.push_back(cur_req);
        pending_reqs.push_back(make_op(OP_LOOKUP, 64'd12, ones, 7'h7F));
        pending_reqs.push_back(make_op(OP_LOOKUP, 64'd99, '0, 7'd0));
        pending_reqs.push_back(make_op(OP_READ, '0, '0, 7'd64));
        pending_reqs.push_back(make_op(OP_REMOVE, 64'd6, '0, 7'd0));
        pending_reqs.push_back(make_op(OP_REMOVE, 64'd6, '0, 7'd0));
        pending_reqs.push_back(make_op(OP_PRUNE, '0, 64'd500, 7'd0));
        pending_reqs.push_back(make_op(OP_READ, '0, '0, 7'd2));
        pending_reqs.push_back(make_op(OP_UNKNOWN_LO, ones, ones, 7'h7F));
        pending_reqs.push_back(make_op(OP_UNKNOWN_HI, '0, '0, 7'd0));
        pending_reqs.push_back(make_op(OP_PRUNE, '0, ones, 7'd0));
        pending_reqs.push_back(make_op(OP_READ, '0, '0, 7'd64));
        drain_pool();

        // Extreme register values and random items; later, long-lived adds fill past capacity to force eviction.
        write_reg(CFG_CHAIN_ID, ones);
        write_reg(CFG_REQ_VERSION, 64'hFF);
        for (int i = 0; i < 130; i++) pending_reqs.push_back(gen_item(1'b0));
        drain_pool();

        write_reg(CFG_CHAIN_ID, rnd64());
        write_reg(CFG_REQ_VERSION, 64'h0);
        for (int i = 0; i < 72; i++) pending_reqs.push_back(gen_item(1'b1));
        pending_reqs.push_back(make_op(OP_READ, '0, '0, 7'd64));
        for (int i = 0; i < 100; i++) pending_reqs.push_back(gen_item(1'b0));
        pending_reqs.push_back(make_op(OP_READ, '0, '0, 7'd64));
        drain_pool();
        repeat (20) @(posedge i_clk);

        $display("covered %0d items and %0d results, %0d read-outs, peak occupancy %0d",
                 n_accepted, n_results, n_reads, peak_occ);
        $display("adds reaching a full table: %0d, long receiver hold-off: %0d",
                 n_evict_tries, did_hold);
        if (n_errors == 0 && expected_resps.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/topp_pkg.sv
design/topp_ram.sv
design/topp_cmp.sv
design/tip_ordered_pending_pool_top.sv
tb/tip_ordered_pending_pool_top_test.sv
